// ===== rtl/core/sm4_pkg.sv =====
package sm4_pkg;

    localparam int NumRounds = 32;
    localparam int RoundIdxW = 5;

    localparam logic [2:0] CFG_KEY_HIGH = 3'd0;
    localparam logic [2:0] CFG_KEY_LOW  = 3'd1;
    localparam logic [2:0] CFG_IV_HIGH  = 3'd2;
    localparam logic [2:0] CFG_IV_LOW   = 3'd3;
    localparam logic [2:0] CFG_MODE     = 3'd4;

    localparam logic [2:0] MODE_ECB_ENC = 3'd0;
    localparam logic [2:0] MODE_ECB_DEC = 3'd1;
    localparam logic [2:0] MODE_CBC_ENC = 3'd2;
    localparam logic [2:0] MODE_CBC_DEC = 3'd3;
    localparam logic [2:0] MODE_CTR128  = 3'd4;
    localparam logic [2:0] MODE_CTR32   = 3'd5;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input block, set up cipher input
        logic restart;  // start key expansion state from key registers
        logic kx_step;  // one key expansion round
        logic enc_step; // one cipher round
        logic finish;   // form result and update chain
    } sm4_cmd_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
        };
        return t[a];
    endfunction

    function automatic logic [31:0] tau(input logic [31:0] a);
        return {sbox(a[31:24]), sbox(a[23:16]), sbox(a[15:8]), sbox(a[7:0])};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // CK word: byte j of word i is (4i+j)*7 mod 256
    function automatic logic [31:0] ck_word(input logic [RoundIdxW-1:0] i);
        logic [7:0] b0;
        b0 = {1'b0, i, 2'b00} * 8'd7;
        return {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
    endfunction

endpackage

// ===== rtl/core/sm4_ctrl.sv =====
module sm4_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic              in_restart,
    input  logic              out_fire,
    output logic              in_ready,
    output logic              out_valid,
    output logic [sm4_pkg::RoundIdxW-1:0] round,
    output sm4_pkg::sm4_cmd_t cmd
);
    import sm4_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_KEYX = 3'd1;
    localparam logic [2:0] ST_RUN  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [RoundIdxW-1:0] cnt_reg, cnt_next;
    logic last;

    assign last      = (cnt_reg == RoundIdxW'(NumRounds - 1));
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign round     = cnt_reg;

    // sequence key expansion, rounds, result
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cmd.load    = 1'b1;
                    cmd.restart = in_restart;
                    cnt_next    = '0;
                    state_next  = in_restart ? ST_KEYX : ST_RUN;
                end
            end
            ST_KEYX: begin
                cmd.kx_step = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (last) state_next = ST_RUN;
            end
            ST_RUN: begin
                cmd.enc_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (last) state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_fire) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/sm4_datapath.sv =====
module sm4_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  sm4_pkg::sm4_cmd_t cmd,
    input  logic [sm4_pkg::RoundIdxW-1:0] round,
    input  logic              cfg_valid,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    input  logic [63:0]       block_high,
    input  logic [63:0]       block_low,
    output logic [127:0]      result
);
    import sm4_pkg::*;

    logic [63:0]  key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic [2:0]   mode_reg;
    logic [127:0] chain_reg, blk_reg, x_reg, result_reg;
    logic [127:0] kx_reg;
    logic [31:0]  rk_mem [NumRounds];
    logic         keys_ready_reg;
    logic         dec;
    logic [RoundIdxW-1:0] rk_idx;
    logic [31:0]  rk, t_enc, l_enc, t_kx, new_rk;
    logic [127:0] cin, chain_cur, e_out, blk_in;

    assign result = result_reg;
    assign dec    = (mode_reg == MODE_ECB_DEC) || (mode_reg == MODE_CBC_DEC);
    assign blk_in = {block_high, block_low};
    // chain as seen by a block after a possible restart
    assign chain_cur = cmd.restart ? {iv_high_reg, iv_low_reg} : chain_reg;

    // select cipher input for the mode
    always_comb begin
        unique case (mode_reg)
            MODE_CBC_ENC:            cin = blk_in ^ chain_cur;
            MODE_CTR128, MODE_CTR32: cin = chain_cur;
            default:                 cin = blk_in;
        endcase
    end

    // one cipher round
    assign rk_idx = dec ? ~round : round;
    assign rk     = keys_ready_reg ? rk_mem[rk_idx] : 32'd0;
    assign t_enc  = tau(x_reg[95:64] ^ x_reg[63:32] ^ x_reg[31:0] ^ rk);
    assign l_enc  = x_reg[127:96] ^ t_enc ^ rotl(t_enc, 2) ^ rotl(t_enc, 10)
                  ^ rotl(t_enc, 18) ^ rotl(t_enc, 24);

    // one key expansion round
    assign t_kx   = tau(kx_reg[95:64] ^ kx_reg[63:32] ^ kx_reg[31:0] ^ ck_word(round));
    assign new_rk = kx_reg[127:96] ^ t_kx ^ rotl(t_kx, 13) ^ rotl(t_kx, 23);

    assign e_out = {x_reg[31:0], x_reg[63:32], x_reg[95:64], x_reg[127:96]};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
            mode_reg     <= MODE_ECB_ENC;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                CFG_IV_HIGH:  iv_high_reg  <= cfg_data;
                CFG_IV_LOW:   iv_low_reg   <= cfg_data;
                CFG_MODE:     mode_reg     <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // chain and readiness state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg      <= '0;
            keys_ready_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                if (cmd.restart) begin
                    chain_reg      <= {iv_high_reg, iv_low_reg};
                    keys_ready_reg <= 1'b1;
                end
            end
            if (cmd.finish) begin
                unique case (mode_reg)
                    MODE_CBC_ENC: chain_reg <= e_out;
                    MODE_CBC_DEC: chain_reg <= blk_reg;
                    MODE_CTR128:  chain_reg <= chain_reg + 128'd1;
                    MODE_CTR32:   chain_reg[31:0] <= chain_reg[31:0] + 32'd1;
                    default: ;
                endcase
            end
        end
    end

    // round key store
    always_ff @(posedge aclk) begin
        if (cmd.kx_step) rk_mem[round] <= new_rk;
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            blk_reg <= blk_in;
            x_reg   <= cin;
            kx_reg  <= {key_high_reg[63:32] ^ FK0, key_high_reg[31:0] ^ FK1,
                        key_low_reg[63:32] ^ FK2, key_low_reg[31:0] ^ FK3};
        end
        if (cmd.kx_step) kx_reg <= {kx_reg[95:0], new_rk};
        if (cmd.enc_step) x_reg <= {x_reg[95:0], l_enc};
        if (cmd.finish) begin
            unique case (mode_reg)
                MODE_ECB_ENC, MODE_ECB_DEC, MODE_CBC_ENC: result_reg <= e_out;
                MODE_CBC_DEC:             result_reg <= e_out ^ chain_reg;
                MODE_CTR128, MODE_CTR32:  result_reg <= e_out ^ blk_reg;
                default:                  result_reg <= '0;
            endcase
        end
    end

endmodule

// ===== rtl/core/sm4_cipher_with_chaining_modes_core.sv =====
// SM4 block cipher core with ECB, CBC, CTR and CTR32 modes.
// Input stream s_*: one 128-bit block per request plus a restart flag in
// s_axis_tuser. A restart expands the key and reloads the chain from the IV.
// Output stream m_*: one 128-bit result per input block.
// Config channel cfg_*: index 0 key_high, 1 key_low, 2 iv_high, 3 iv_low,
// 4 cipher_mode; write only while the core is idle.
// Sequence: on accept, key expansion runs first when restart is set (key
// schedule runs one round per cycle), then the cipher round logic runs one
// round per cycle, then a finish step forms the result, then the output
// handoff; blocks do not overlap.
// Reset clears config registers, chain and key-ready state; round keys are
// not cleared. When the receiver stalls, the result holds on m_axis_tdata
// and no new block is taken until it is accepted.
module sm4_cipher_with_chaining_modes_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // block_high[63:0], block_low[127:64]
    input  logic [0:0]   s_axis_tuser,  // restart[0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // result_high[63:0], result_low[127:64]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    import sm4_pkg::*;

    sm4_cmd_t cmd;
    logic [RoundIdxW-1:0] round;
    logic [127:0] res;

    assign cfg_ready = 1'b1;

    sm4_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (s_axis_tvalid & s_axis_tready),
        .in_restart (s_axis_tuser[0]),
        .out_fire   (m_axis_tvalid & m_axis_tready),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .round      (round),
        .cmd        (cmd)
    );

    sm4_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .round      (round),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .block_high (s_axis_tdata[63:0]),
        .block_low  (s_axis_tdata[127:64]),
        .result     (res)
    );

    // high field first in tdata
    assign m_axis_tdata = {res[63:0], res[127:64]};

endmodule

// ===== rtl/core/sm4_checker.sv =====
module sm4_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid)) else $error("input ready while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
        else $error("core not busy after accept");
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready |=> s_axis_tready)
        else $error("core not idle after result");
endmodule

bind sm4_cipher_with_chaining_modes_core sm4_checker u_sm4_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
